// ===== rtl/acsp_pkg.sv =====
// ----------------------------------------------------------------------------
// acsp_pkg
// Shared types, constants and decode functions of the CSI sequence parser.
// ----------------------------------------------------------------------------
package acsp_pkg;

  // Parameter slots kept per sequence
  localparam int unsigned MAX_PARAMS = 8;
  localparam int unsigned IDX_W      = $clog2(MAX_PARAMS);
  localparam int unsigned PCNT_W     = $clog2(MAX_PARAMS + 1);

  // Command codes reported on completion
  typedef enum logic [3:0] {
    CMD_UP      = 4'd0,
    CMD_DOWN    = 4'd1,
    CMD_FWD     = 4'd2,
    CMD_BACK    = 4'd3,
    CMD_POS     = 4'd4,
    CMD_ERASE_D = 4'd5,
    CMD_ERASE_L = 4'd6,
    CMD_COLUMN  = 4'd7,
    CMD_ATTR    = 4'd8,
    CMD_MODE    = 4'd9,
    CMD_UNKNOWN = 4'd10
  } acsp_code_e;

  // Characters of interest
  localparam logic [7:0] CHAR_ESC      = 8'h1B;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_EQUAL    = 8'h3D;
  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_H_LOWER  = 8'h68;

  // Attribute word layout
  localparam logic [15:0] ATTR_BOLD      = 16'h0100;
  localparam logic [15:0] ATTR_UNDERLINE = 16'h0200;
  localparam logic [15:0] ATTR_REVERSE   = 16'h0400;
  localparam logic [15:0] FG_KEEP        = 16'hFFF0;
  localparam logic [15:0] BG_KEEP        = 16'hFF0F;

  // SGR parameter values
  localparam logic [7:0] SGR_BOLD     = 8'd1;
  localparam logic [7:0] SGR_UNDER    = 8'd4;
  localparam logic [7:0] SGR_REVERSE  = 8'd7;
  localparam logic [7:0] SGR_FG_LO    = 8'd30;
  localparam logic [7:0] SGR_FG_HI    = 8'd37;
  localparam logic [7:0] SGR_BG_LO    = 8'd40;
  localparam logic [7:0] SGR_BG_HI    = 8'd47;
  localparam logic [7:0] SGR_NO_BOLD  = 8'd101;
  localparam logic [7:0] SGR_NO_UNDER = 8'd104;
  localparam logic [7:0] SGR_NO_REV   = 8'd107;
  localparam logic [7:0] SGR_FG_DEF   = 8'd130;
  localparam logic [7:0] SGR_BG_DEF   = 8'd140;
  // Offsets that turn a color parameter into code 8 + n
  localparam logic [7:0] SGR_FG_BIAS  = 8'd22;
  localparam logic [7:0] SGR_BG_BIAS  = 8'd32;

  // Controller to datapath
  typedef struct packed {
    logic       clear_params;
    logic       start_num;
    logic       add_digit;
    logic       latch_fin;
    acsp_code_e fin_code;
    logic       sgr_clear;
    logic       sgr_step;
    logic       load_out;
  } acsp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       is_esc;
    logic       is_lbracket;
    logic       is_equal;
    logic       is_semi;
    logic       is_h;
    logic       is_digit;
    acsp_code_e code;
    logic       has_params;
    logic       params_full;
    logic       first_zero;
    logic       sgr_last;
    logic       out_free;
  } acsp_stat_t;

  function automatic acsp_code_e lookup_code(input logic [7:0] b);
    acsp_code_e c;
    case (b)
      "A":     c = CMD_UP;
      "B":     c = CMD_DOWN;
      "C":     c = CMD_FWD;
      "D":     c = CMD_BACK;
      "H":     c = CMD_POS;
      "f":     c = CMD_POS;
      "J":     c = CMD_ERASE_D;
      "K":     c = CMD_ERASE_L;
      "G":     c = CMD_COLUMN;
      "m":     c = CMD_ATTR;
      "h":     c = CMD_MODE;
      default: c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

  // Apply one SGR parameter to the attribute word
  function automatic logic [15:0] sgr_apply(input logic [15:0] attr, input logic [7:0] p);
    logic [15:0] a;
    a = attr;
    if (p == SGR_BOLD) begin
      a = a | ATTR_BOLD;
    end else if (p == SGR_UNDER) begin
      a = a | ATTR_UNDERLINE;
    end else if (p == SGR_REVERSE) begin
      a = a | ATTR_REVERSE;
    end else if (p inside {[SGR_FG_LO:SGR_FG_HI]}) begin
      a = (a & FG_KEEP) | {12'h000, 4'(p - SGR_FG_BIAS)};
    end else if (p inside {[SGR_BG_LO:SGR_BG_HI]}) begin
      a = (a & BG_KEEP) | {8'h00, 4'(p - SGR_BG_BIAS), 4'h0};
    end else if (p == SGR_NO_BOLD) begin
      a = a & ~ATTR_BOLD;
    end else if (p == SGR_NO_UNDER) begin
      a = a & ~ATTR_UNDERLINE;
    end else if (p == SGR_NO_REV) begin
      a = a & ~ATTR_REVERSE;
    end else if (p == SGR_FG_DEF) begin
      a = a & FG_KEEP;
    end else if (p == SGR_BG_DEF) begin
      a = a & BG_KEEP;
    end
    return a;
  endfunction

endpackage

// ===== rtl/ansi_csi_sequence_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_csi_sequence_parser
// CSI escape sequence parser with SGR attribute tracking.
// ----------------------------------------------------------------------------
// The parser takes one terminal byte per input item and recognizes ESC [
// control sequences, including the ESC [ = n h screen-mode form. ESC always
// restarts a sequence and drops any sequence in progress. Decimal parameters
// go into up to MAX_PARAMS slots (each saturating, a digit that would pass
// 255 is ignored); semicolons are skipped; numbers beyond the last slot are
// read and discarded. The byte that ends a sequence produces one result item
// with the command code, the final character, the parameter count, the first
// two parameters and the attribute word. A final 'm' first updates the kept
// 16-bit attribute word per SGR rules (a first parameter of 0 clears it).
// Sequencing: a byte that does not end a sequence is simply accepted. A byte
// that ends a sequence is accepted, and then the result register is loaded as
// soon as it is free (empty, or its previous result being taken). A final 'm'
// puts the SGR walk between the two: it applies one parameter slot per cycle
// through a single update unit, one step per stored parameter (a single step
// when the word is cleared). The result register is separate from the parser,
// so bytes keep flowing while a result waits, until the next sequence
// completes.
// ----------------------------------------------------------------------------
module ansi_csi_sequence_parser import acsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  command_o,
  output logic [7:0]  final_char_o,
  output logic [3:0]  param_count_o,
  output logic [7:0]  first_param_o,
  output logic [7:0]  second_param_o,
  output logic [15:0] attribute_o
);

  acsp_cmd_t  cmd;
  acsp_stat_t stat;

  // Recognizer and sequencer: decides what each accepted byte does
  acsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage: parameter slots, attribute word, result register
  acsp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_in_i      (byte_in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .final_char_o   (final_char_o),
    .param_count_o  (param_count_o),
    .first_param_o  (first_param_o),
    .second_param_o (second_param_o),
    .attribute_o    (attribute_o)
  );

`ifndef ASSERT_OFF
  // An SGR result whose first parameter is zero carries a cleared word
  a_sgr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_o == CMD_ATTR && first_param_o == 8'd0)
      |-> attribute_o == 16'h0000)
    else $error("SGR with zero first parameter left attribute set");

  // A single collected parameter leaves the second one at zero
  a_one_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && param_count_o == 4'd1) |-> second_param_o == 8'd0)
    else $error("second parameter set with only one collected");

  // A new result is only loaded while input is held off
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result loaded while input was open");
`endif

endmodule

// ===== rtl/acsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// acsp_ctrl
// Sequence recognizer and step sequencer of the CSI sequence parser.
// ----------------------------------------------------------------------------
module acsp_ctrl import acsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  acsp_stat_t stat_i,
  output acsp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SGR,
    SEQ_EMIT
  } seq_e;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_ESC,
    PS_BRACKET,
    PS_EQUAL,
    PS_NUM,
    PS_NUM_DROP
  } parse_e;

  seq_e       seq_q, seq_d;
  parse_e     parse_q, parse_d;
  parse_e     saved_q, saved_d;
  parse_e     coll_st;
  logic       collect;
  acsp_code_e fin_code;

  always_comb begin
    seq_d    = seq_q;
    parse_d  = parse_q;
    saved_d  = saved_q;
    cmd_o    = '0;
    cmd_o.fin_code = CMD_UNKNOWN;
    collect  = 1'b0;
    coll_st  = PS_BRACKET;
    fin_code = CMD_UNKNOWN;
    case (seq_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.is_esc) begin
            parse_d = PS_ESC;
            saved_d = PS_IDLE;
            cmd_o.clear_params = 1'b1;
          end else begin
            case (parse_q)
              PS_ESC: begin
                parse_d = stat_i.is_lbracket ? PS_BRACKET : PS_IDLE;
              end
              PS_BRACKET, PS_EQUAL: begin
                collect = 1'b1;
                coll_st = parse_q;
              end
              PS_NUM, PS_NUM_DROP: begin
                if (stat_i.is_digit) begin
                  if (parse_q == PS_NUM) begin
                    cmd_o.add_digit = 1'b1;
                  end
                end else begin
                  // number ends: handle the byte in the state before it
                  collect = 1'b1;
                  coll_st = (saved_q == PS_EQUAL) ? PS_EQUAL : PS_BRACKET;
                  saved_d = PS_IDLE;
                end
              end
              default: begin
                parse_d = PS_IDLE;
              end
            endcase
            if (collect) begin
              if (stat_i.is_digit) begin
                saved_d = coll_st;
                if (!stat_i.params_full) begin
                  cmd_o.start_num = 1'b1;
                  parse_d = PS_NUM;
                end else begin
                  parse_d = PS_NUM_DROP;
                end
              end else if (stat_i.is_semi) begin
                parse_d = coll_st;
              end else if (coll_st == PS_BRACKET && stat_i.is_equal) begin
                parse_d = PS_EQUAL;
              end else begin
                if (coll_st == PS_BRACKET) begin
                  fin_code = stat_i.code;
                end else if (stat_i.has_params && stat_i.is_h) begin
                  fin_code = CMD_MODE;
                end
                parse_d = PS_IDLE;
                saved_d = PS_IDLE;
                cmd_o.latch_fin = 1'b1;
                cmd_o.fin_code  = fin_code;
                seq_d = (fin_code == CMD_ATTR) ? SEQ_SGR : SEQ_EMIT;
              end
            end
          end
        end
      end
      SEQ_SGR: begin
        if (stat_i.first_zero) begin
          cmd_o.sgr_clear = 1'b1;
          seq_d = SEQ_EMIT;
        end else begin
          cmd_o.sgr_step = 1'b1;
          if (stat_i.sgr_last) begin
            seq_d = SEQ_EMIT;
          end
        end
      end
      SEQ_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          seq_d = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SEQ_IDLE;
      parse_q <= PS_IDLE;
      saved_q <= PS_IDLE;
    end else begin
      seq_q   <= seq_d;
      parse_q <= parse_d;
      saved_q <= saved_d;
    end
  end

  assign in_ready_o = (seq_q == SEQ_IDLE);

endmodule

// ===== rtl/acsp_dp.sv =====
// ----------------------------------------------------------------------------
// acsp_dp
// Parameter slots, attribute word and result register of the CSI parser.
// ----------------------------------------------------------------------------
module acsp_dp import acsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_in_i,
  input  acsp_cmd_t   cmd_i,
  output acsp_stat_t  stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  command_o,
  output logic [7:0]  final_char_o,
  output logic [3:0]  param_count_o,
  output logic [7:0]  first_param_o,
  output logic [7:0]  second_param_o,
  output logic [15:0] attribute_o
);

  logic [7:0]        slot_q [MAX_PARAMS];
  logic [PCNT_W-1:0] total_q;
  logic [7:0]        cur_q;
  logic [15:0]       attr_q;
  logic [IDX_W-1:0]  idx_q;
  acsp_code_e        fin_code_q;
  logic [7:0]        fin_char_q;
  logic              out_valid_q;

  logic [3:0]        dig;
  logic [11:0]       grown;
  logic              fits;
  logic [IDX_W-1:0]  wr_idx;
  logic              out_free;

  assign dig    = 4'(byte_in_i - CHAR_ZERO);
  // cur * 10 + digit
  assign grown  = {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0} + {8'h00, dig};
  assign fits   = (grown <= 12'd255);
  assign wr_idx = IDX_W'(total_q - PCNT_W'(1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.is_esc      = (byte_in_i == CHAR_ESC);
    stat_o.is_lbracket = (byte_in_i == CHAR_LBRACKET);
    stat_o.is_equal    = (byte_in_i == CHAR_EQUAL);
    stat_o.is_semi     = (byte_in_i == CHAR_SEMI);
    stat_o.is_h        = (byte_in_i == CHAR_H_LOWER);
    stat_o.is_digit    = (byte_in_i inside {[CHAR_ZERO:CHAR_NINE]});
    stat_o.code        = lookup_code(byte_in_i);
    stat_o.has_params  = (total_q != '0);
    stat_o.params_full = (total_q == PCNT_W'(MAX_PARAMS));
    stat_o.first_zero  = (slot_q[0] == 8'd0);
    stat_o.sgr_last    = ((PCNT_W'(idx_q) + PCNT_W'(1)) == total_q);
    stat_o.out_free    = out_free;
  end

  // Parameter slots, count and attribute word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PARAMS; i++) begin
        slot_q[i] <= 8'd0;
      end
      total_q     <= '0;
      attr_q      <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_params) begin
        for (int i = 0; i < MAX_PARAMS; i++) begin
          slot_q[i] <= 8'd0;
        end
        total_q <= '0;
      end else if (cmd_i.start_num) begin
        slot_q[total_q[IDX_W-1:0]] <= {4'h0, dig};
        total_q <= total_q + PCNT_W'(1);
      end else if (cmd_i.add_digit && fits) begin
        slot_q[wr_idx] <= grown[7:0];
      end
      if (cmd_i.sgr_clear) begin
        attr_q <= 16'h0000;
      end else if (cmd_i.sgr_step) begin
        attr_q <= sgr_apply(attr_q, slot_q[idx_q]);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_num) begin
      cur_q <= {4'h0, dig};
    end else if (cmd_i.add_digit && fits) begin
      cur_q <= grown[7:0];
    end
    if (cmd_i.latch_fin) begin
      fin_code_q <= cmd_i.fin_code;
      fin_char_q <= byte_in_i;
      idx_q      <= '0;
    end else if (cmd_i.sgr_step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.load_out) begin
      command_o      <= fin_code_q;
      final_char_o   <= fin_char_q;
      param_count_o  <= 4'(total_q);
      first_param_o  <= slot_q[0];
      second_param_o <= slot_q[1];
      attribute_o    <= attr_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
